// ===== hdl/pmrq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrq_pkg
// Shared types and constants of the priority match record queue.
// ----------------------------------------------------------------------------
package pmrq_pkg;

  localparam int DEPTH        = 64;
  localparam int PAYLOAD_BITS = 32;
  localparam int PRI_W        = 8;
  localparam int CMD_W        = 3;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int GROUP        = 8;
  localparam int NGROUP       = (DEPTH + GROUP - 1) / GROUP;
  localparam int GRP_W        = $clog2(GROUP + 1);

  typedef logic [PAYLOAD_BITS-1:0] pay_t;
  typedef logic [PRI_W-1:0]        pri_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_TAKE   = 3'd3,
    CMD_COUNT  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_PULL_ALL,
    CELL_PULL_TAIL
  } cell_op_e;

  typedef struct packed {
    pri_t pri;
    pay_t pay;
  } entry_t;

  typedef struct packed {
    logic     capture;
    logic     scan;
    cell_op_e op;
    pri_t     pri;
  } cell_ctrl_t;

endpackage

// ===== hdl/priority_match_record_queue_top.sv =====
// ----------------------------------------------------------------------------
// priority_match_record_queue_top
// Ordered record list with priority search, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  | handshake          | fields
//  ---------+--------------------+---------------------------------------------
//  command  | start / busy       | command_i, priority_req_i, payload_i
//  result   | done_o (strobe)    | status_o, found_priority_o, found_payload_o,
//           |                    | match_count_o, occupancy_o
//
// A command is taken when start is high and busy low. Its result shows on the
// done_o strobe after the cells compare, the first-match chain and group counts
// are registered, and the row shifts while the result is selected.
// The next command may start in the cycle the result shows, so commands do not
// overlap. Reset empties the list at once; no clearing pass.
// The result is not held: done_o lasts one cycle and cannot be stalled.
module priority_match_record_queue_top
  import pmrq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [7:0]        priority_req_i,
  input  logic [31:0]       payload_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [7:0]        found_priority_o,
  output logic [31:0]       found_payload_o,
  output logic [6:0]        match_count_o,
  output logic [6:0]        occupancy_o
);

  state_e           state_q, state_d;
  logic [CMD_W-1:0] cmd_q;
  entry_t           new_q;
  cnt_t             count_q, count_d;
  cell_ctrl_t       ctrl;
  logic             accept;

  entry_t           cell_entry [DEPTH];
  logic [DEPTH:0]   ahead;
  logic [DEPTH-1:0] match_v, first_v;
  cnt_t             tally;

  logic             done_d;
  status_e          status_d;
  pri_t             fpri_d, sel_pri;
  pay_t             fpay_d, sel_pay;
  cnt_t             mcount_d;
  logic             hit;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // --- cell row ---
  assign ahead[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_w, right_w;
    if (i == 0) begin : g_head
      assign left_w = new_q;
    end else begin : g_body
      assign left_w = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_w = cell_entry[i];
    end else begin : g_inner
      assign right_w = cell_entry[i+1];
    end

    pmrq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .valid_i  (CNT_W'(i) < count_q),
      .left_i   (left_w),
      .right_i  (right_w),
      .ahead_i  (ahead[i]),
      .ahead_o  (ahead[i+1]),
      .match_o  (match_v[i]),
      .first_o  (first_v[i]),
      .entry_o  (cell_entry[i])
    );
  end

  pmrq_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .scan_i  (ctrl.scan),
    .match_i (match_v),
    .count_o (tally)
  );

  // one-hot pick of the first match
  always_comb begin
    sel_pri = '0;
    sel_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_v[i]) begin
        sel_pri = sel_pri | cell_entry[i].pri;
        sel_pay = sel_pay | cell_entry[i].pay;
      end
    end
  end

  assign hit = |first_v;

  // --- sequencer ---
  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = accept ? ST_SCAN : ST_IDLE;
      ST_SCAN: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.capture = (state_q == ST_IDLE) && accept;
    ctrl.scan    = (state_q == ST_SCAN);
    ctrl.op      = CELL_HOLD;
    ctrl.pri     = priority_req_i;
    count_d      = count_q;
    done_d       = 1'b0;
    status_d     = STAT_DONE;
    fpri_d       = '0;
    fpay_d       = '0;
    mcount_d     = '0;
    if (state_q == ST_EXEC) begin
      done_d = 1'b1;
      unique case (cmd_q)
        CMD_INSERT: begin
          if (count_q == CNT_W'(DEPTH)) begin
            status_d = STAT_FULL;
          end else begin
            ctrl.op = CELL_PUSH;
            count_d = count_q + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (count_q == '0) begin
            status_d = STAT_MISS;
          end else begin
            fpri_d  = cell_entry[0].pri;
            fpay_d  = cell_entry[0].pay;
            ctrl.op = CELL_PULL_ALL;
            count_d = count_q - 1'b1;
          end
        end
        CMD_PEEK, CMD_TAKE: begin
          if (!hit) begin
            status_d = STAT_MISS;
          end else begin
            fpri_d = sel_pri;
            fpay_d = sel_pay;
            if (cmd_q == CMD_TAKE) begin
              ctrl.op = CELL_PULL_TAIL;
              count_d = count_q - 1'b1;
            end
          end
        end
        CMD_COUNT: mcount_d = tally;
        default:   status_d = STAT_MISS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_o  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= command_i;
      new_q.pri <= priority_req_i;
      new_q.pay <= pay_t'(payload_i);
    end
    if (done_d) begin
      status_o         <= status_d;
      found_priority_o <= fpri_d;
      found_payload_o  <= 32'(fpay_d);
      match_count_o    <= 7'(mcount_d);
      occupancy_o      <= 7'(count_d);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $onehot0(first_v))
    else $error("more than one first match");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result beat missing");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ===== hdl/pmrq_cell.sv =====
// ----------------------------------------------------------------------------
// pmrq_cell
// One list position: holds a record, compares it and shifts with neighbours.
// ----------------------------------------------------------------------------
module pmrq_cell
  import pmrq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  entry_t     left_i,
  input  entry_t     right_i,
  input  logic       ahead_i,
  output logic       ahead_o,
  output logic       match_o,
  output logic       first_o,
  output entry_t     entry_o
);

  entry_t entry_q;
  logic   match_q, first_q, after_q;

  // a hit somewhere in front of this cell, or here
  assign ahead_o = ahead_i | match_q;
  assign match_o = match_q;
  assign first_o = first_q;
  assign entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      first_q <= 1'b0;
      after_q <= 1'b0;
    end else begin
      if (ctrl_i.capture) begin
        match_q <= valid_i && (entry_q.pri == ctrl_i.pri);
      end
      if (ctrl_i.scan) begin
        first_q <= match_q & ~ahead_i;
        after_q <= match_q | ahead_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_HOLD:      entry_q <= entry_q;
      CELL_PUSH:      entry_q <= left_i;
      CELL_PULL_ALL:  entry_q <= right_i;
      CELL_PULL_TAIL: if (after_q) entry_q <= right_i;
      default:        entry_q <= entry_q;
    endcase
  end

endmodule

// ===== hdl/pmrq_tally.sv =====
// ----------------------------------------------------------------------------
// pmrq_tally
// Counts match flags: per-group counts registered, then summed.
// ----------------------------------------------------------------------------
module pmrq_tally
  import pmrq_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             scan_i,
  input  logic [DEPTH-1:0] match_i,
  output cnt_t             count_o
);

  logic [GRP_W-1:0] grp_d [NGROUP];
  logic [GRP_W-1:0] grp_q [NGROUP];

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < GROUP; b++) begin
        if (g * GROUP + b < DEPTH) begin
          grp_d[g] = grp_d[g] + GRP_W'(match_i[g * GROUP + b]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < NGROUP; g++) grp_q[g] <= '0;
    end else if (scan_i) begin
      for (int g = 0; g < NGROUP; g++) grp_q[g] <= grp_d[g];
    end
  end

  always_comb begin
    count_o = '0;
    for (int g = 0; g < NGROUP; g++) begin
      count_o = count_o + CNT_W'(grp_q[g]);
    end
  end

endmodule
